### rtl/core/nls_pkg.sv
package nls_pkg;

  localparam int TableDepth   = 4;
  localparam int MaxSelected  = 4;
  localparam int IdxW         = 2;
  localparam int CntW         = 3;
  localparam int DistW        = 34;
  localparam logic [DistW-1:0] RadiusReset = 34'd6553600;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpUpdate = 2'd1,
    OpQuery  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StDist,
    StSort,
    StEmit
  } back_state_e;

  // one classified request in the queue between front and back
  typedef struct packed {
    op_e          op;
    logic         kind;
    logic [1:0]   index;
    logic [47:0]  pos;
    logic [47:0]  dir;
    logic [47:0]  color;
    logic [15:0]  inten;
    logic [15:0]  cutoff;
  } req_t;

  typedef struct packed {
    logic         kind;
    logic         found;
    logic [1:0]   index;
    logic [2:0]   count;
    logic [33:0]  dsq;
    logic [47:0]  color;
    logic [15:0]  inten;
    logic [47:0]  dir;
    logic [15:0]  cutoff;
    logic         last;
  } res_t;

  // squared difference of two Q8.8 coordinates
  function automatic logic [33:0] sq_diff(input logic [15:0] a, input logic [15:0] b);
    logic signed [16:0] d;
    logic [33:0] p;
    d = $signed({a[15], a}) - $signed({b[15], b});
    p = 34'($signed(d) * $signed(d));
    return p;
  endfunction

endpackage

### rtl/core/nls_front.sv
module nls_front
  import nls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_req_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output req_t        q_req_o
);

  // two-entry queue; ops that do nothing are dropped here
  req_t       mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign push       = in_valid_i && !in_stall_o && (in_req_i.op != OpNone);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? !wp_q : wp_q;
    rp_d  = pop ? !rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_req_i;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count step");

endmodule

### rtl/core/nls_back.sv
module nls_back
  import nls_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [33:0]  radius_i,
  input  logic         q_valid_i,
  output logic         q_pop_o,
  input  req_t         q_req_i,
  output logic         busy_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output res_t         out_res_o
);

  // light tables, flops (4 entries each)
  logic [47:0] ppos_q [TableDepth];
  logic [47:0] pcol_q [TableDepth];
  logic [15:0] pint_q [TableDepth];
  logic [47:0] spos_q [TableDepth];
  logic [47:0] sdir_q [TableDepth];
  logic [47:0] scol_q [TableDepth];
  logic [15:0] sint_q [TableDepth];
  logic [15:0] scut_q [TableDepth];
  logic [CntW-1:0] pcnt_q, scnt_q;

  back_state_e st_q, st_d;
  logic        kind_q;       // kind under work
  logic [47:0] obj_q;
  logic [IdxW-1:0] ent_q;    // entry whose distance is computed
  logic [33:0] dist_q [TableDepth];
  logic [TableDepth-1:0] ok_q;
  logic [IdxW-1:0] ord_q [MaxSelected];
  logic [CntW-1:0] nsel_q, emit_q;

  logic        take;
  logic [CntW-1:0] cnt_sel;
  logic [47:0] epos;
  logic [33:0] dcur;
  logic        have;
  logic [IdxW-1:0] best;
  logic        res_go;
  logic [IdxW-1:0] ix;
  res_t        res;

  assign cnt_sel = kind_q ? scnt_q : pcnt_q;
  assign epos    = kind_q ? spos_q[ent_q] : ppos_q[ent_q];
  assign dcur    = sq_diff(obj_q[47:32], epos[47:32]) + sq_diff(obj_q[31:16], epos[31:16])
                 + sq_diff(obj_q[15:0], epos[15:0]);

  // nearest remaining qualifying entry, lower index on ties
  always_comb begin
    have = 1'b0;
    best = '0;
    for (int i = 0; i < TableDepth; i++) begin
      if (ok_q[i] && (!have || dist_q[i] < dist_q[best])) begin
        best = IdxW'(i);
        have = 1'b1;
      end
    end
  end

  assign take   = (st_q == StIdle) && q_valid_i;
  assign q_pop_o = take;
  assign busy_o  = (st_q != StIdle) || out_valid_o;
  assign res_go  = (st_q == StEmit) && (!out_valid_o || !out_stall_i);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (take && q_req_i.op == OpQuery) st_d = StDist;
      StDist: if ({1'b0, ent_q} + 3'd1 >= CntW'(TableDepth)) st_d = StSort;
      StSort: if (!have || nsel_q == CntW'(MaxSelected)) st_d = StEmit;
      StEmit: if (res_go && (emit_q + 3'd1 >= nsel_q || nsel_q == '0)
                  && kind_q) st_d = StIdle;
              else if (res_go && (emit_q + 3'd1 >= nsel_q || nsel_q == '0))
                st_d = StDist;
      default: st_d = StIdle;
    endcase
  end

  // result being emitted
  always_comb begin
    ix = ord_q[emit_q[IdxW-1:0]];
    res = '0;
    res.kind = kind_q;
    if (nsel_q != '0) begin
      res.found  = 1'b1;
      res.index  = ix;
      res.count  = nsel_q;
      res.dsq    = dist_q[ix];
      res.color  = kind_q ? scol_q[ix] : pcol_q[ix];
      res.inten  = kind_q ? sint_q[ix] : pint_q[ix];
      res.dir    = kind_q ? sdir_q[ix] : 48'd0;
      res.cutoff = kind_q ? scut_q[ix] : 16'd0;
    end
    res.last = kind_q && (nsel_q == '0 || emit_q + 3'd1 >= nsel_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      pcnt_q      <= '0;
      scnt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (take && q_req_i.op == OpAdd) begin
        if (!q_req_i.kind && pcnt_q < CntW'(TableDepth)) pcnt_q <= pcnt_q + 3'd1;
        if (q_req_i.kind && scnt_q < CntW'(TableDepth)) scnt_q <= scnt_q + 3'd1;
      end
      if (res_go) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_go) begin
      out_res_o <= res;
      emit_q    <= emit_q + 3'd1;
      if (emit_q + 3'd1 >= nsel_q || nsel_q == '0) begin
        kind_q <= 1'b1;
        ent_q  <= '0;
        ok_q   <= '0;
        nsel_q <= '0;
      end
    end
    case (st_q)
      StIdle: begin
        kind_q <= 1'b0;
        obj_q  <= q_req_i.pos;
        ent_q  <= '0;
        ok_q   <= '0;
        nsel_q <= '0;
        if (take && q_req_i.op == OpAdd) begin
          if (!q_req_i.kind && pcnt_q < CntW'(TableDepth)) begin
            ppos_q[pcnt_q[IdxW-1:0]] <= q_req_i.pos;
            pcol_q[pcnt_q[IdxW-1:0]] <= q_req_i.color;
            pint_q[pcnt_q[IdxW-1:0]] <= q_req_i.inten;
          end
          if (q_req_i.kind && scnt_q < CntW'(TableDepth)) begin
            spos_q[scnt_q[IdxW-1:0]] <= q_req_i.pos;
            sdir_q[scnt_q[IdxW-1:0]] <= q_req_i.dir;
            scol_q[scnt_q[IdxW-1:0]] <= q_req_i.color;
            sint_q[scnt_q[IdxW-1:0]] <= q_req_i.inten;
            scut_q[scnt_q[IdxW-1:0]] <= q_req_i.cutoff;
          end
        end
        if (take && q_req_i.op == OpUpdate) begin
          if (!q_req_i.kind && {1'b0, q_req_i.index} < pcnt_q) begin
            pcol_q[q_req_i.index] <= q_req_i.color;
            pint_q[q_req_i.index] <= q_req_i.inten;
          end
          if (q_req_i.kind && {1'b0, q_req_i.index} < scnt_q) begin
            sdir_q[q_req_i.index] <= q_req_i.dir;
            scol_q[q_req_i.index] <= q_req_i.color;
            sint_q[q_req_i.index] <= q_req_i.inten;
            scut_q[q_req_i.index] <= q_req_i.cutoff;
          end
        end
      end
      StDist: begin
        dist_q[ent_q] <= dcur;
        ok_q[ent_q]   <= ({1'b0, ent_q} < cnt_sel) && (dcur <= radius_i);
        ent_q         <= ent_q + 1'b1;
        emit_q        <= '0;
      end
      StSort: begin
        if (have && nsel_q != CntW'(MaxSelected)) begin
          ord_q[nsel_q[IdxW-1:0]] <= best;
          ok_q[best] <= 1'b0;
          nsel_q     <= nsel_q + 3'd1;
        end
      end
      default: ;
    endcase
  end

  a_nsel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nsel_q <= CntW'(MaxSelected) || st_q == StIdle || st_q == StDist) else $error("nsel");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= CntW'(TableDepth) && scnt_q <= CntW'(TableDepth)) else $error("count");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_go && res.last |=> st_q == StIdle) else $error("last without idle");

endmodule

### rtl/core/nearest_light_select.sv
// channel | dir | handshake          | payload
// in      | in  | in_valid_i/stall_o | operation .. cutoff
// out     | out | out_valid_o/stall_i| result_kind .. last
// cfg     | in  | cfg_valid_i/ready_o| cfg_data_i (radius_squared)
// A query is popped, then for each light kind in turn passes the distance, sort and emit
// states, giving one result per cycle unless the output stalls (at least one result per kind).
// Add/update are applied by the back end in its idle state. A two-entry queue decouples input.
// Reset clears counts and control; table contents are undefined until written.
// Output stall holds the result register and keeps the back end in its emit state.
module nearest_light_select
  import nls_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [33:0]  cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   operation_i,
  input  logic         light_kind_i,
  input  logic [1:0]   light_index_i,
  input  logic [15:0]  pos_x_i,
  input  logic [15:0]  pos_y_i,
  input  logic [15:0]  pos_z_i,
  input  logic [47:0]  direction_packed_i,
  input  logic [47:0]  color_packed_i,
  input  logic [15:0]  intensity_i,
  input  logic [15:0]  cutoff_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         result_kind_o,
  output logic         found_o,
  output logic [1:0]   selected_index_o,
  output logic [2:0]   selected_count_o,
  output logic [33:0]  distance_squared_o,
  output logic [47:0]  light_color_o,
  output logic [15:0]  light_intensity_o,
  output logic [47:0]  light_direction_o,
  output logic [15:0]  light_cutoff_o,
  output logic         last_o
);

  logic [33:0] radius_q;
  req_t        in_req, q_req;
  logic        q_valid, q_pop, busy;
  res_t        res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) radius_q <= RadiusReset;
    else if (cfg_valid_i && cfg_ready_o) radius_q <= cfg_data_i;
  end

  always_comb begin
    in_req.op     = op_e'(operation_i);
    in_req.kind   = light_kind_i;
    in_req.index  = light_index_i;
    in_req.pos    = {pos_x_i, pos_y_i, pos_z_i};
    in_req.dir    = direction_packed_i;
    in_req.color  = color_packed_i;
    in_req.inten  = intensity_i;
    in_req.cutoff = cutoff_i;
  end

  nls_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i(in_req),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  nls_back u_back (
    .clk_i, .rst_ni, .radius_i(radius_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_req_i(q_req), .busy_o(busy), .out_valid_o, .out_stall_i, .out_res_o(res)
  );

  assign result_kind_o      = res.kind;
  assign found_o            = res.found;
  assign selected_index_o   = res.index;
  assign selected_count_o   = res.count;
  assign distance_squared_o = res.dsq;
  assign light_color_o      = res.color;
  assign light_intensity_o  = res.inten;
  assign light_direction_o  = res.dir;
  assign light_cutoff_o     = res.cutoff;
  assign last_o             = res.last;

  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result without busy");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> selected_count_o != 3'd0) else $error("found count");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> distance_squared_o == '0) else $error("empty result");

endmodule
